// ===== hw/rtl/qpm_pkg.sv =====
package qpm_pkg;

   // Q30 angle constants for the half-angle unit
   localparam logic [32:0] TWO_PI_Q30   = 33'd6746518852;
   localparam logic [32:0] PI_Q30       = 33'd3373259426;
   localparam logic [32:0] HALF_PI_Q30  = 33'd1686629713;
   localparam logic [32:0] INV_GAIN_Q30 = 33'd652032874;
   localparam int          ATAN_N       = 31;

   // angle reduction phases: estimate quotient, subtract multiple, final correction
   localparam logic [4:0]  MD_EST = 5'd2;
   localparam logic [4:0]  MD_SUB = 5'd1;
   localparam logic [4:0]  MD_FIX = 5'd0;

   // microprogram segment entry points
   localparam int          PC_W    = 7;
   localparam logic [6:0]  TR_BASE = 7'd0;
   localparam logic [6:0]  RT_BASE = 7'd30;
   localparam logic [6:0]  SC_BASE = 7'd53;
   localparam logic [6:0]  MX_BASE = 7'd59;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MOD, ST_FOLD, ST_CORDIC, ST_CSWR, ST_RD, ST_MUL, ST_ACC, ST_DONE
   } qpm_state_type;

   typedef enum logic [1:0] {
      FN_SET, FN_TRANSLATE, FN_ROTATE, FN_SCALE
   } qpm_func_type;

   typedef enum logic [2:0] {
      MU_MADD, MU_MSUB, MU_RADD, MU_RSUB, MU_DBL
   } qpm_kind_type;

   typedef enum logic [1:0] {
      NX_STEP, NX_MATRIX, NX_DONE
   } qpm_next_type;

   // operand and destination codes; named registers first, then scratch, then matrix
   typedef enum logic [5:0] {
      OP_ONE, OP_P0, OP_P1, OP_P2, OP_QW, OP_QX, OP_QY, OP_QZ,
      OP_S0, OP_S1, OP_S2, OP_V0, OP_V1, OP_V2, OP_AMT, OP_C, OP_SN,
      OP_U0, OP_U1, OP_U2, OP_T0, OP_T1, OP_T2, OP_D, OP_R0, OP_R1, OP_R2,
      OP_N0, OP_N1, OP_N2, OP_N3,
      OP_M00, OP_M01, OP_M02, OP_M10, OP_M11, OP_M12, OP_M20, OP_M21, OP_M22
   } qpm_opnd_type;

   localparam int NAMED_N = 17;
   localparam int SCR_N   = 14;
   localparam int MAT_N   = 9;

   typedef struct packed {
      qpm_kind_type kind;
      logic         clr;
      qpm_opnd_type src_a;
      qpm_opnd_type src_b;
      logic         wr;
      qpm_opnd_type dst;
      qpm_next_type nxt;
   } qpm_uop_type;

   typedef struct packed {
      logic         accept;
      qpm_func_type func;
      logic         mod_step;
      logic [4:0]   mod_k;
      logic         fold;
      logic         cor_step;
      logic [4:0]   cor_i;
      logic         cs_wr;
      logic         rd;
      logic         mul;
      logic         acc;
      logic         out_load;
      qpm_uop_type  uop;
   } qpm_cmd_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:    r = 30'd843314857;
         5'd1:    r = 30'd497837829;
         5'd2:    r = 30'd263043837;
         5'd3:    r = 30'd133525159;
         5'd4:    r = 30'd67021687;
         5'd5:    r = 30'd33543516;
         5'd6:    r = 30'd16775851;
         5'd7:    r = 30'd8388437;
         5'd8:    r = 30'd4194283;
         5'd9:    r = 30'd2097149;
         default: r = 30'd1 << (5'd30 - i);
      endcase
      return r;
   endfunction

   function automatic qpm_uop_type mk(input qpm_kind_type k, input logic c,
                                      input qpm_opnd_type a, input qpm_opnd_type b,
                                      input logic w, input qpm_opnd_type d,
                                      input qpm_next_type n);
      qpm_uop_type u;
      u.kind  = k;
      u.clr   = c;
      u.src_a = a;
      u.src_b = b;
      u.wr    = w;
      u.dst   = d;
      u.nxt   = n;
      return u;
   endfunction

   // microprogram: translate, rotate tail, add scale, matrix build
   function automatic qpm_uop_type ucode(input logic [6:0] pc);
      qpm_uop_type u;
      case (pc)
         7'd0:  u = mk(MU_MADD, 1'b1, OP_QY, OP_V2, 1'b0, OP_ONE, NX_STEP);
         7'd1:  u = mk(MU_MSUB, 1'b0, OP_QZ, OP_V1, 1'b1, OP_U0, NX_STEP);
         7'd2:  u = mk(MU_MADD, 1'b1, OP_QZ, OP_V0, 1'b0, OP_ONE, NX_STEP);
         7'd3:  u = mk(MU_MSUB, 1'b0, OP_QX, OP_V2, 1'b1, OP_U1, NX_STEP);
         7'd4:  u = mk(MU_MADD, 1'b1, OP_QX, OP_V1, 1'b0, OP_ONE, NX_STEP);
         7'd5:  u = mk(MU_MSUB, 1'b0, OP_QY, OP_V0, 1'b1, OP_U2, NX_STEP);
         7'd6:  u = mk(MU_MADD, 1'b1, OP_QY, OP_U2, 1'b0, OP_ONE, NX_STEP);
         7'd7:  u = mk(MU_MSUB, 1'b0, OP_QZ, OP_U1, 1'b1, OP_T0, NX_STEP);
         7'd8:  u = mk(MU_MADD, 1'b1, OP_QZ, OP_U0, 1'b0, OP_ONE, NX_STEP);
         7'd9:  u = mk(MU_MSUB, 1'b0, OP_QX, OP_U2, 1'b1, OP_T1, NX_STEP);
         7'd10: u = mk(MU_MADD, 1'b1, OP_QX, OP_U1, 1'b0, OP_ONE, NX_STEP);
         7'd11: u = mk(MU_MSUB, 1'b0, OP_QY, OP_U0, 1'b1, OP_T2, NX_STEP);
         7'd12: u = mk(MU_MADD, 1'b1, OP_U0, OP_QW, 1'b0, OP_ONE, NX_STEP);
         7'd13: u = mk(MU_RADD, 1'b0, OP_T0, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd14: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd15: u = mk(MU_RADD, 1'b0, OP_V0, OP_ONE, 1'b1, OP_D, NX_STEP);
         7'd16: u = mk(MU_RADD, 1'b1, OP_P0, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd17: u = mk(MU_MADD, 1'b0, OP_D, OP_AMT, 1'b1, OP_P0, NX_STEP);
         7'd18: u = mk(MU_MADD, 1'b1, OP_U1, OP_QW, 1'b0, OP_ONE, NX_STEP);
         7'd19: u = mk(MU_RADD, 1'b0, OP_T1, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd20: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd21: u = mk(MU_RADD, 1'b0, OP_V1, OP_ONE, 1'b1, OP_D, NX_STEP);
         7'd22: u = mk(MU_RADD, 1'b1, OP_P1, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd23: u = mk(MU_MADD, 1'b0, OP_D, OP_AMT, 1'b1, OP_P1, NX_STEP);
         7'd24: u = mk(MU_MADD, 1'b1, OP_U2, OP_QW, 1'b0, OP_ONE, NX_STEP);
         7'd25: u = mk(MU_RADD, 1'b0, OP_T2, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd26: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd27: u = mk(MU_RADD, 1'b0, OP_V2, OP_ONE, 1'b1, OP_D, NX_STEP);
         7'd28: u = mk(MU_RADD, 1'b1, OP_P2, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd29: u = mk(MU_MADD, 1'b0, OP_D, OP_AMT, 1'b1, OP_P2, NX_MATRIX);
         7'd30: u = mk(MU_MADD, 1'b1, OP_V0, OP_SN, 1'b1, OP_R0, NX_STEP);
         7'd31: u = mk(MU_MADD, 1'b1, OP_V1, OP_SN, 1'b1, OP_R1, NX_STEP);
         7'd32: u = mk(MU_MADD, 1'b1, OP_V2, OP_SN, 1'b1, OP_R2, NX_STEP);
         7'd33: u = mk(MU_MADD, 1'b1, OP_QW, OP_C,  1'b0, OP_ONE, NX_STEP);
         7'd34: u = mk(MU_MSUB, 1'b0, OP_QX, OP_R0, 1'b0, OP_ONE, NX_STEP);
         7'd35: u = mk(MU_MSUB, 1'b0, OP_QY, OP_R1, 1'b0, OP_ONE, NX_STEP);
         7'd36: u = mk(MU_MSUB, 1'b0, OP_QZ, OP_R2, 1'b1, OP_N0, NX_STEP);
         7'd37: u = mk(MU_MADD, 1'b1, OP_QW, OP_R0, 1'b0, OP_ONE, NX_STEP);
         7'd38: u = mk(MU_MADD, 1'b0, OP_QX, OP_C,  1'b0, OP_ONE, NX_STEP);
         7'd39: u = mk(MU_MADD, 1'b0, OP_QY, OP_R2, 1'b0, OP_ONE, NX_STEP);
         7'd40: u = mk(MU_MSUB, 1'b0, OP_QZ, OP_R1, 1'b1, OP_N1, NX_STEP);
         7'd41: u = mk(MU_MADD, 1'b1, OP_QW, OP_R1, 1'b0, OP_ONE, NX_STEP);
         7'd42: u = mk(MU_MADD, 1'b0, OP_QY, OP_C,  1'b0, OP_ONE, NX_STEP);
         7'd43: u = mk(MU_MADD, 1'b0, OP_QZ, OP_R0, 1'b0, OP_ONE, NX_STEP);
         7'd44: u = mk(MU_MSUB, 1'b0, OP_QX, OP_R2, 1'b1, OP_N2, NX_STEP);
         7'd45: u = mk(MU_MADD, 1'b1, OP_QW, OP_R2, 1'b0, OP_ONE, NX_STEP);
         7'd46: u = mk(MU_MADD, 1'b0, OP_QZ, OP_C,  1'b0, OP_ONE, NX_STEP);
         7'd47: u = mk(MU_MADD, 1'b0, OP_QX, OP_R1, 1'b0, OP_ONE, NX_STEP);
         7'd48: u = mk(MU_MSUB, 1'b0, OP_QY, OP_R0, 1'b1, OP_N3, NX_STEP);
         7'd49: u = mk(MU_RADD, 1'b1, OP_N0, OP_ONE, 1'b1, OP_QW, NX_STEP);
         7'd50: u = mk(MU_RADD, 1'b1, OP_N1, OP_ONE, 1'b1, OP_QX, NX_STEP);
         7'd51: u = mk(MU_RADD, 1'b1, OP_N2, OP_ONE, 1'b1, OP_QY, NX_STEP);
         7'd52: u = mk(MU_RADD, 1'b1, OP_N3, OP_ONE, 1'b1, OP_QZ, NX_MATRIX);
         7'd53: u = mk(MU_RADD, 1'b1, OP_S0, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd54: u = mk(MU_RADD, 1'b0, OP_V0, OP_ONE, 1'b1, OP_S0, NX_STEP);
         7'd55: u = mk(MU_RADD, 1'b1, OP_S1, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd56: u = mk(MU_RADD, 1'b0, OP_V1, OP_ONE, 1'b1, OP_S1, NX_STEP);
         7'd57: u = mk(MU_RADD, 1'b1, OP_S2, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd58: u = mk(MU_RADD, 1'b0, OP_V2, OP_ONE, 1'b1, OP_S2, NX_MATRIX);
         7'd59: u = mk(MU_MSUB, 1'b1, OP_QY, OP_QY, 1'b0, OP_ONE, NX_STEP);
         7'd60: u = mk(MU_MSUB, 1'b0, OP_QZ, OP_QZ, 1'b0, OP_ONE, NX_STEP);
         7'd61: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd62: u = mk(MU_RADD, 1'b0, OP_ONE, OP_ONE, 1'b1, OP_U0, NX_STEP);
         7'd63: u = mk(MU_MADD, 1'b1, OP_QX, OP_QY, 1'b0, OP_ONE, NX_STEP);
         7'd64: u = mk(MU_MSUB, 1'b0, OP_QW, OP_QZ, 1'b0, OP_ONE, NX_STEP);
         7'd65: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b1, OP_U1, NX_STEP);
         7'd66: u = mk(MU_MADD, 1'b1, OP_QX, OP_QZ, 1'b0, OP_ONE, NX_STEP);
         7'd67: u = mk(MU_MADD, 1'b0, OP_QW, OP_QY, 1'b0, OP_ONE, NX_STEP);
         7'd68: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b1, OP_U2, NX_STEP);
         7'd69: u = mk(MU_MADD, 1'b1, OP_QX, OP_QY, 1'b0, OP_ONE, NX_STEP);
         7'd70: u = mk(MU_MADD, 1'b0, OP_QW, OP_QZ, 1'b0, OP_ONE, NX_STEP);
         7'd71: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b1, OP_T0, NX_STEP);
         7'd72: u = mk(MU_MSUB, 1'b1, OP_QX, OP_QX, 1'b0, OP_ONE, NX_STEP);
         7'd73: u = mk(MU_MSUB, 1'b0, OP_QZ, OP_QZ, 1'b0, OP_ONE, NX_STEP);
         7'd74: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd75: u = mk(MU_RADD, 1'b0, OP_ONE, OP_ONE, 1'b1, OP_T1, NX_STEP);
         7'd76: u = mk(MU_MADD, 1'b1, OP_QY, OP_QZ, 1'b0, OP_ONE, NX_STEP);
         7'd77: u = mk(MU_MSUB, 1'b0, OP_QW, OP_QX, 1'b0, OP_ONE, NX_STEP);
         7'd78: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b1, OP_T2, NX_STEP);
         7'd79: u = mk(MU_MADD, 1'b1, OP_QX, OP_QZ, 1'b0, OP_ONE, NX_STEP);
         7'd80: u = mk(MU_MSUB, 1'b0, OP_QW, OP_QY, 1'b0, OP_ONE, NX_STEP);
         7'd81: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b1, OP_R0, NX_STEP);
         7'd82: u = mk(MU_MADD, 1'b1, OP_QY, OP_QZ, 1'b0, OP_ONE, NX_STEP);
         7'd83: u = mk(MU_MADD, 1'b0, OP_QW, OP_QX, 1'b0, OP_ONE, NX_STEP);
         7'd84: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b1, OP_R1, NX_STEP);
         7'd85: u = mk(MU_MSUB, 1'b1, OP_QX, OP_QX, 1'b0, OP_ONE, NX_STEP);
         7'd86: u = mk(MU_MSUB, 1'b0, OP_QY, OP_QY, 1'b0, OP_ONE, NX_STEP);
         7'd87: u = mk(MU_DBL,  1'b0, OP_ONE, OP_ONE, 1'b0, OP_ONE, NX_STEP);
         7'd88: u = mk(MU_RADD, 1'b0, OP_ONE, OP_ONE, 1'b1, OP_R2, NX_STEP);
         7'd89: u = mk(MU_MADD, 1'b1, OP_U0, OP_S0, 1'b1, OP_M00, NX_STEP);
         7'd90: u = mk(MU_MADD, 1'b1, OP_U1, OP_S1, 1'b1, OP_M01, NX_STEP);
         7'd91: u = mk(MU_MADD, 1'b1, OP_U2, OP_S2, 1'b1, OP_M02, NX_STEP);
         7'd92: u = mk(MU_MADD, 1'b1, OP_T0, OP_S0, 1'b1, OP_M10, NX_STEP);
         7'd93: u = mk(MU_MADD, 1'b1, OP_T1, OP_S1, 1'b1, OP_M11, NX_STEP);
         7'd94: u = mk(MU_MADD, 1'b1, OP_T2, OP_S2, 1'b1, OP_M12, NX_STEP);
         7'd95: u = mk(MU_MADD, 1'b1, OP_R0, OP_S0, 1'b1, OP_M20, NX_STEP);
         7'd96: u = mk(MU_MADD, 1'b1, OP_R1, OP_S1, 1'b1, OP_M21, NX_STEP);
         7'd97: u = mk(MU_MADD, 1'b1, OP_R2, OP_S2, 1'b1, OP_M22, NX_DONE);
         default: u = mk(MU_DBL, 1'b0, OP_ONE, OP_ONE, 1'b0, OP_ONE, NX_DONE);
      endcase
      return u;
   endfunction

endpackage

// ===== hw/rtl/qpm_datapath.sv =====
module qpm_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  qpm_pkg::qpm_cmd_type cmd,
   input  logic signed [31:0]  vec_x,
   input  logic signed [31:0]  vec_y,
   input  logic signed [31:0]  vec_z,
   input  logic signed [31:0]  amount,
   input  logic signed [31:0]  quat_w,
   input  logic signed [31:0]  quat_x,
   input  logic signed [31:0]  quat_y,
   input  logic signed [31:0]  quat_z,
   input  logic signed [31:0]  scale_x,
   input  logic signed [31:0]  scale_y,
   input  logic signed [31:0]  scale_z,
   output logic signed [31:0]  out_mat [9],
   output logic signed [31:0]  out_pos [3]
);
   import qpm_pkg::*;

   localparam int ACC_W = 68 - FRAC_BITS;
   localparam int AW    = 62 - FRAC_BITS;
   localparam int MW    = AW + 2;
   localparam int CW    = 36;
   localparam int QSH   = 30 - FRAC_BITS;
   // the angle magnitude is at most 2**(AW-2); its top 25 bits feed the quotient estimate
   localparam int LS    = AW - 26;
   localparam logic [27:0] RCP = 28'((64'd1 << (32 + LS)) / 64'(TWO_PI_Q30));
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(64'sh7FFFFFFF);
   localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);
   localparam logic signed [CW-1:0] PI_S   = CW'(PI_Q30);
   localparam logic signed [CW-1:0] TPI_S  = CW'(TWO_PI_Q30);
   localparam logic signed [CW-1:0] HPI_S  = CW'(HALF_PI_Q30);

   function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > MAXV) r = 32'sh7FFFFFFF;
      else if (v < MINV) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // pose, operands and intermediate registers
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] quat_ff [4];
   logic signed [31:0] scl_ff [3];
   logic signed [31:0] vec_ff [3];
   logic signed [31:0] amt_ff, cos_ff, sin_ff;
   logic signed [31:0] mat_ff [MAT_N];
   logic signed [31:0] scr_ff [SCR_N];
   logic signed [31:0] a_ff, b_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [MW-1:0]      mag_ff, mag_in;
   logic [20:0]        q_ff, q_in;
   logic               aneg_ff;
   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic               flip_ff, flip_in;
   logic signed [31:0] rsp_mat_ff [9];
   logic signed [31:0] rsp_pos_ff [3];
   logic signed [31:0] named [NAMED_N];
   logic signed [31:0] wval, cos_in, sin_in;

   // named operand view
   always_comb begin
      named[0]  = ONE;
      named[1]  = pos_ff[0];
      named[2]  = pos_ff[1];
      named[3]  = pos_ff[2];
      named[4]  = quat_ff[0];
      named[5]  = quat_ff[1];
      named[6]  = quat_ff[2];
      named[7]  = quat_ff[3];
      named[8]  = scl_ff[0];
      named[9]  = scl_ff[1];
      named[10] = scl_ff[2];
      named[11] = vec_ff[0];
      named[12] = vec_ff[1];
      named[13] = vec_ff[2];
      named[14] = amt_ff;
      named[15] = cos_ff;
      named[16] = sin_ff;
   end

   // accumulate one term, saturate on store
   logic signed [63:0]       psh;
   logic signed [ACC_W-1:0]  pterm, aterm, base;
   always_comb begin
      psh   = prod_ff >>> FRAC_BITS;
      pterm = psh[ACC_W-1:0];
      aterm = {{(ACC_W-32){a_ff[31]}}, a_ff};
      base  = cmd.uop.clr ? '0 : acc_ff;
      case (cmd.uop.kind)
         MU_MADD: acc_in = base + pterm;
         MU_MSUB: acc_in = base - pterm;
         MU_RADD: acc_in = base + aterm;
         MU_RSUB: acc_in = base - aterm;
         default: acc_in = acc_ff <<< 1;
      endcase
      wval = sat_acc(acc_in);
   end

   // half angle: reduce, fold, and one rotation step
   logic [MW-1:0]        tps, qt;
   logic [24:0]          hi;
   logic [52:0]          qprod;
   logic signed [CW-1:0] rs, zf;
   logic signed [ACC_W-1:0] amt_w;
   logic signed [AW-1:0] zsh, z0;
   logic signed [CW-1:0] xf, yf, dx, dy, at;
   always_comb begin
      amt_w  = ACC_W'(amount);
      zsh    = AW'(amt_w) <<< QSH;
      z0     = zsh >>> 1;
      mag_in = z0[AW-1] ? MW'(-z0) : MW'(z0);
      mag_in[MW-1:AW] = '0;
      tps    = MW'(TWO_PI_Q30);
      // quotient estimate by reciprocal, at most one below the true quotient
      hi     = 25'(mag_ff >> LS);
      qprod  = 53'(hi) * 53'(RCP);
      q_in   = qprod[52:32];
      qt     = MW'(q_ff) * MW'(TWO_PI_Q30);
      rs     = aneg_ff ? -CW'(mag_ff[33:0]) : CW'(mag_ff[33:0]);
      if (rs > PI_S) rs = rs - TPI_S;
      if (rs < -PI_S) rs = rs + TPI_S;
      flip_in = 1'b0;
      zf      = rs;
      if (rs > HPI_S) begin
         zf = rs - PI_S;
         flip_in = 1'b1;
      end else if (rs < -HPI_S) begin
         zf = rs + PI_S;
         flip_in = 1'b1;
      end
      dx = cy_ff >>> cmd.cor_i;
      dy = cx_ff >>> cmd.cor_i;
      at = CW'(atan_q30(cmd.cor_i));
      if (cz_ff >= 0) begin
         cx_in = cx_ff - dx;
         cy_in = cy_ff + dy;
         cz_in = cz_ff - at;
      end else begin
         cx_in = cx_ff + dx;
         cy_in = cy_ff - dy;
         cz_in = cz_ff + at;
      end
      xf     = flip_ff ? -cx_ff : cx_ff;
      yf     = flip_ff ? -cy_ff : cy_ff;
      cos_in = sat_acc(ACC_W'(xf >>> QSH));
      sin_in = sat_acc(ACC_W'(yf >>> QSH));
   end

   // angle reduction and rotation-step registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mag_ff  <= mag_in;
         aneg_ff <= z0[AW-1];
      end else if (cmd.mod_step) begin
         case (cmd.mod_k)
            MD_EST:  q_ff <= q_in;
            MD_SUB:  mag_ff <= mag_ff - qt;
            default: if (mag_ff >= tps) mag_ff <= mag_ff - tps;
         endcase
      end
      if (cmd.fold) begin
         cx_ff   <= CW'(INV_GAIN_Q30);
         cy_ff   <= '0;
         cz_ff   <= zf;
         flip_ff <= flip_in;
      end else if (cmd.cor_step) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
   end

   // operand fetch, product, accumulator
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         a_ff <= (cmd.uop.src_a >= OP_U0) ?
                 scr_ff[4'(6'(cmd.uop.src_a) - 6'(OP_U0))] : named[5'(cmd.uop.src_a)];
         b_ff <= (cmd.uop.src_b >= OP_U0) ?
                 scr_ff[4'(6'(cmd.uop.src_b) - 6'(OP_U0))] : named[5'(cmd.uop.src_b)];
      end
      if (cmd.mul) prod_ff <= a_ff * b_ff;
      if (cmd.acc) acc_ff <= acc_in;
   end

   // scratch store
   always_ff @(posedge clock) begin
      if (cmd.acc && cmd.uop.wr && cmd.uop.dst >= OP_U0 && cmd.uop.dst <= OP_N3)
         scr_ff[4'(6'(cmd.uop.dst) - 6'(OP_U0))] <= wval;
   end

   // matrix entries
   always_ff @(posedge clock) begin
      if (cmd.acc && cmd.uop.wr && cmd.uop.dst >= OP_M00)
         mat_ff[4'(6'(cmd.uop.dst) - 6'(OP_M00))] <= wval;
   end

   // item operands and half-angle results
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         vec_ff[0] <= vec_x;
         vec_ff[1] <= vec_y;
         vec_ff[2] <= vec_z;
         amt_ff    <= amount;
      end
      if (cmd.cs_wr) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   // pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '{default: '0};
         quat_ff <= '{ONE, 32'sd0, 32'sd0, 32'sd0};
         scl_ff  <= '{default: ONE};
      end else if (cmd.accept && cmd.func == FN_SET) begin
         pos_ff  <= '{vec_x, vec_y, vec_z};
         quat_ff <= '{quat_w, quat_x, quat_y, quat_z};
         scl_ff  <= '{scale_x, scale_y, scale_z};
      end else if (cmd.acc && cmd.uop.wr) begin
         if (cmd.uop.dst >= OP_P0 && cmd.uop.dst <= OP_P2)
            pos_ff[2'(6'(cmd.uop.dst) - 6'(OP_P0))] <= wval;
         if (cmd.uop.dst >= OP_QW && cmd.uop.dst <= OP_QZ)
            quat_ff[2'(6'(cmd.uop.dst) - 6'(OP_QW))] <= wval;
         if (cmd.uop.dst >= OP_S0 && cmd.uop.dst <= OP_S2)
            scl_ff[2'(6'(cmd.uop.dst) - 6'(OP_S0))] <= wval;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_mat_ff <= mat_ff;
         rsp_pos_ff <= pos_ff;
      end
   end

   assign out_mat = rsp_mat_ff;
   assign out_pos = rsp_pos_ff;

endmodule

// ===== hw/rtl/qpm_control.sv =====
module qpm_control #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output qpm_pkg::qpm_cmd_type cmd
);
   import qpm_pkg::*;

   localparam int NSTEP     = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

   qpm_state_type   state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [4:0]      k_ff, k_in;
   logic [4:0]      i_ff, i_in;
   logic            vld_ff, vld_in;
   qpm_uop_type     uop;

   assign uop = ucode(pc_ff);

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         vld_ff   <= vld_in;
      end
   end

   // sequence one item
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      cmd          = '0;
      cmd.func     = qpm_func_type'(req_tuser);
      cmd.uop      = uop;
      cmd.mod_k    = k_ff;
      cmd.cor_i    = i_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (qpm_func_type'(req_tuser))
                  FN_SET: begin
                     pc_in    = MX_BASE;
                     state_in = ST_RD;
                  end
                  FN_TRANSLATE: begin
                     pc_in    = TR_BASE;
                     state_in = ST_RD;
                  end
                  FN_ROTATE: begin
                     k_in     = MD_EST;
                     state_in = ST_MOD;
                  end
                  default: begin
                     pc_in    = SC_BASE;
                     state_in = ST_RD;
                  end
               endcase
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (k_ff == MD_FIX) state_in = ST_FOLD;
            else k_in = k_ff - 5'd1;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            i_in     = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.cor_step = 1'b1;
            i_in = i_ff + 5'd1;
            if (i_ff == 5'(NSTEP - 1)) state_in = ST_CSWR;
         end
         ST_CSWR: begin
            cmd.cs_wr = 1'b1;
            pc_in     = RT_BASE;
            state_in  = ST_RD;
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            unique case (uop.nxt)
               NX_STEP: begin
                  pc_in    = pc_ff + 7'd1;
                  state_in = ST_RD;
               end
               NX_MATRIX: begin
                  pc_in    = MX_BASE;
                  state_in = ST_RD;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_DONE: begin
            if (!vld_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid: set on load, drop on transfer
   always_comb begin
      if (cmd.out_load) vld_in = 1'b1;
      else if (rsp_tready) vld_in = 1'b0;
      else vld_in = vld_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = vld_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!vld_ff || rsp_tready))
      else $error("result register overwritten before transfer");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("result not presented after load");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sequencer did not start on accepted item");
   a_acc_in_prog: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (pc_ff <= 7'd97))
      else $error("microprogram counter out of range");

endmodule

// ===== hw/rtl/quaternion_pose_matrix_unit.sv =====
// Pose to matrix unit. Holds a position, an orientation quaternion and a per-axis
// scale in signed fixed point (FRAC_BITS fraction bits) and applies one operation
// per input transfer: load pose, translate along the rotated vector, rotate by an
// axis-angle, or add to the scale. Each item returns the top three rows of the
// translate-rotate-scale matrix. One shared 32x32 multiplier with an accumulator
// runs a microprogram whose steps each read operands, multiply and accumulate; the
// matrix build takes 39 steps, after 30 steps for translate, 23 for rotate or 6 for
// scale (load has none). Rotate first runs a half-angle reduction (estimate,
// subtract, correct), a fold, a CORDIC rotation and a cosine/sine write. The next item is taken while a
// result waits; a second finished result holds until the first one transfers.
module quaternion_pose_matrix_unit #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vec_x, vec_y, vec_z, amount, quat_w, quat_x, quat_y, quat_z,
   // scale_x, scale_y, scale_z (32 bits each)
   input  logic [351:0] req_tdata,
   // func
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // row0_col0..row0_col3, row1_col0..row1_col3, row2_col0..row2_col3 (32 bits each)
   output logic [383:0] rsp_tdata
);
   import qpm_pkg::*;

   qpm_cmd_type        cmd;
   logic signed [31:0] out_mat [9];
   logic signed [31:0] out_pos [3];

   qpm_control #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd)
   );

   qpm_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .vec_x  ($signed(req_tdata[31:0])),
      .vec_y  ($signed(req_tdata[63:32])),
      .vec_z  ($signed(req_tdata[95:64])),
      .amount ($signed(req_tdata[127:96])),
      .quat_w ($signed(req_tdata[159:128])),
      .quat_x ($signed(req_tdata[191:160])),
      .quat_y ($signed(req_tdata[223:192])),
      .quat_z ($signed(req_tdata[255:224])),
      .scale_x($signed(req_tdata[287:256])),
      .scale_y($signed(req_tdata[319:288])),
      .scale_z($signed(req_tdata[351:320])),
      .out_mat(out_mat),
      .out_pos(out_pos)
   );

   // pack result rows
   assign rsp_tdata = {out_pos[2], out_mat[8], out_mat[7], out_mat[6],
                       out_pos[1], out_mat[5], out_mat[4], out_mat[3],
                       out_pos[0], out_mat[2], out_mat[1], out_mat[0]};

endmodule

// ===== sim/qpm_checker.sv =====
module qpm_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [351:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [383:0] rsp_tdata,
   output int           error_count,
   output int           pending_count
);
   import qpm_pkg::*;

   localparam int FB = 16;
   localparam int STEPS = 16;

   longint pos [3];
   longint ori [4];
   longint scl [3];
   logic [383:0] matrix_queue [$];
   int mismatch_total;

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // arithmetic shift floors for negative values
   function automatic longint fmul(input longint a, input longint b);
      return (a * b) >>> FB;
   endfunction

   function automatic longint arctan(input int i);
      case (i)
         0: return 843314857;
         1: return 497837829;
         2: return 263043837;
         3: return 133525159;
         4: return 67021687;
         5: return 33543516;
         6: return 16775851;
         7: return 8388437;
         8: return 4194283;
         9: return 2097149;
         default: return 64'sd1 << (30 - i);
      endcase
   endfunction

   task automatic half_cos_sin(input longint ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit neg;
      z = (ang * (64'sd1 << (30 - FB))) >>> 1;
      x = 652032874;
      y = 0;
      neg = 0;
      z = z % 64'sd6746518852;
      if (z > 64'sd3373259426) z -= 64'sd6746518852;
      if (z < -64'sd3373259426) z += 64'sd6746518852;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426;
         neg = 1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426;
         neg = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= arctan(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += arctan(i);
         end
         x = nx;
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      c = sat32(x >>> (30 - FB));
      s = sat32(y >>> (30 - FB));
   endtask

   task automatic apply_pose_op(input logic [1:0] fn, input logic [351:0] d);
      longint v [3];
      longint amt, u [3], t [3], dir, c, s, r [3], pw, px, py, pz;
      longint qw, qx, qy, qz;
      for (int k = 0; k < 3; k++) v[k] = longint'($signed(d[32*k +: 32]));
      amt = longint'($signed(d[96 +: 32]));
      qw = ori[0]; qx = ori[1]; qy = ori[2]; qz = ori[3];
      case (qpm_func_type'(fn))
         FN_SET: begin
            for (int k = 0; k < 3; k++) begin
               pos[k] = v[k];
               scl[k] = longint'($signed(d[256 + 32*k +: 32]));
            end
            for (int k = 0; k < 4; k++) ori[k] = longint'($signed(d[128 + 32*k +: 32]));
         end
         FN_TRANSLATE: begin
            u[0] = sat32(fmul(qy, v[2]) - fmul(qz, v[1]));
            u[1] = sat32(fmul(qz, v[0]) - fmul(qx, v[2]));
            u[2] = sat32(fmul(qx, v[1]) - fmul(qy, v[0]));
            t[0] = sat32(fmul(qy, u[2]) - fmul(qz, u[1]));
            t[1] = sat32(fmul(qz, u[0]) - fmul(qx, u[2]));
            t[2] = sat32(fmul(qx, u[1]) - fmul(qy, u[0]));
            for (int k = 0; k < 3; k++) begin
               dir = sat32(v[k] + 2 * (fmul(u[k], qw) + t[k]));
               pos[k] = sat32(pos[k] + fmul(dir, amt));
            end
         end
         FN_ROTATE: begin
            half_cos_sin(amt, c, s);
            for (int k = 0; k < 3; k++) r[k] = sat32(fmul(v[k], s));
            pw = qw; px = qx; py = qy; pz = qz;
            ori[0] = sat32(fmul(pw, c) - fmul(px, r[0]) - fmul(py, r[1]) - fmul(pz, r[2]));
            ori[1] = sat32(fmul(pw, r[0]) + fmul(px, c) + fmul(py, r[2]) - fmul(pz, r[1]));
            ori[2] = sat32(fmul(pw, r[1]) + fmul(py, c) + fmul(pz, r[0]) - fmul(px, r[2]));
            ori[3] = sat32(fmul(pw, r[2]) + fmul(pz, c) + fmul(px, r[1]) - fmul(py, r[0]));
         end
         default: begin
            for (int k = 0; k < 3; k++) scl[k] = sat32(scl[k] + v[k]);
         end
      endcase
   endtask

   function automatic logic [383:0] pose_matrix();
      longint w, x, y, z, one, m [3][3];
      logic [383:0] flat;
      one = 64'sd1 << FB;
      w = ori[0]; x = ori[1]; y = ori[2]; z = ori[3];
      m[0][0] = sat32(one - 2 * (fmul(y, y) + fmul(z, z)));
      m[0][1] = sat32(2 * (fmul(x, y) - fmul(w, z)));
      m[0][2] = sat32(2 * (fmul(x, z) + fmul(w, y)));
      m[1][0] = sat32(2 * (fmul(x, y) + fmul(w, z)));
      m[1][1] = sat32(one - 2 * (fmul(x, x) + fmul(z, z)));
      m[1][2] = sat32(2 * (fmul(y, z) - fmul(w, x)));
      m[2][0] = sat32(2 * (fmul(x, z) - fmul(w, y)));
      m[2][1] = sat32(2 * (fmul(y, z) + fmul(w, x)));
      m[2][2] = sat32(one - 2 * (fmul(x, x) + fmul(y, y)));
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++)
            flat[128*r + 32*c +: 32] = 32'(sat32(fmul(m[r][c], scl[c])));
         flat[128*r + 96 +: 32] = 32'(pos[r]);
      end
      return flat;
   endfunction

   assign error_count = mismatch_total;
   assign pending_count = matrix_queue.size();

   // track pose on each input transfer, compare on each output transfer
   always @(posedge clock) begin
      logic [383:0] want;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            pos[k] = 0;
            scl[k] = 64'sd1 << FB;
         end
         ori[0] = 64'sd1 << FB;
         ori[1] = 0; ori[2] = 0; ori[3] = 0;
         matrix_queue.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (matrix_queue.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               want = matrix_queue.pop_front();
               for (int f = 0; f < 12; f++) begin
                  if (rsp_tdata[32*f +: 32] !== want[32*f +: 32]) begin
                     mismatch_total++;
                     if (mismatch_total <= 10)
                        $display("row%0d_col%0d: expected %h got %h", f / 4, f % 4,
                                 want[32*f +: 32], rsp_tdata[32*f +: 32]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_pose_op(req_tuser, req_tdata);
            matrix_queue.push_back(pose_matrix());
         end
      end
   end

endmodule

// ===== sim/tb_quaternion_pose_matrix_unit.sv =====
module tb_quaternion_pose_matrix_unit;
   import qpm_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [351:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [383:0] rsp_tdata;
   int           error_count;
   int           pending_count;
   bit           hold_output = 0;
   bit           sending_done = 0;

   localparam logic [31:0] ONE_Q = 32'h0001_0000;

   always #5 clock = ~clock;

   quaternion_pose_matrix_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   qpm_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 4);
   endfunction

   // mostly moderate values so poses stay meaningful, some full-range noise
   function automatic logic [31:0] pick_q(input bit wide);
      int r;
      r = $urandom_range(0, 9);
      if (wide || r == 0) return $urandom;
      if (r == 1) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fffffff};
      return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
   endfunction

   // drop valid only across a gap, so back-to-back items keep it high
   task automatic send_op(input qpm_func_type fn, input logic [351:0] d);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tdata <= d;
      req_tuser <= fn;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [351:0] pose_word(input logic [31:0] f [11]);
      logic [351:0] d;
      for (int k = 0; k < 11; k++) d[32*k +: 32] = f[k];
      return d;
   endfunction

   task automatic send_random(input bit wide);
      logic [31:0] f [11];
      int sel;
      for (int k = 0; k < 11; k++) f[k] = pick_q(wide);
      sel = $urandom_range(0, 9);
      if (!wide && sel < 2) begin
         // unit quat_w and unit scale fields; the operation itself is picked at random
         f[4] = ONE_Q; f[8] = ONE_Q; f[9] = ONE_Q; f[10] = ONE_Q;
      end
      send_op(qpm_func_type'($urandom_range(0, 3)), pose_word(f));
   endtask

   // receiver: random stalls, plus one long hold-off
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_output = 0;
         end
         g = gap_len();
         if ($urandom_range(0, 3) == 0 && g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   initial begin
      logic [31:0] f [11];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes and every operation
      foreach (f[k]) f[k] = 32'h7fffffff;
      send_op(FN_TRANSLATE, pose_word(f));
      send_op(FN_ROTATE, pose_word(f));
      send_op(FN_SCALE, pose_word(f));
      send_op(FN_SET, pose_word(f));
      foreach (f[k]) f[k] = 32'h80000000;
      send_op(FN_SET, pose_word(f));
      send_op(FN_TRANSLATE, pose_word(f));
      send_op(FN_ROTATE, pose_word(f));
      send_op(FN_SCALE, pose_word(f));
      foreach (f[k]) f[k] = '0;
      f[4] = ONE_Q; f[8] = ONE_Q; f[9] = ONE_Q; f[10] = ONE_Q;
      send_op(FN_SET, pose_word(f));
      // rotate about z by pi/2, pi, -pi, 3pi and 0
      f[2] = ONE_Q;
      f[3] = 32'd102944; send_op(FN_ROTATE, pose_word(f));
      f[3] = 32'd205887; send_op(FN_ROTATE, pose_word(f));
      f[3] = -32'sd205887; send_op(FN_ROTATE, pose_word(f));
      f[3] = 32'd617662; send_op(FN_ROTATE, pose_word(f));
      f[3] = 0; send_op(FN_ROTATE, pose_word(f));
      f[0] = ONE_Q; f[2] = 0; f[3] = 32'd3 << 16;
      send_op(FN_TRANSLATE, pose_word(f));
      f[0] = 32'hffff0000; send_op(FN_SCALE, pose_word(f));
      // pressure: block the output while inputs keep coming
      hold_output = 1;
      for (int n = 0; n < 12; n++) send_random(0);
      for (int n = 0; n < 560; n++) send_random(0);
      for (int n = 0; n < 60; n++) send_random(1);
      req_tvalid <= 0;
      sending_done = 1;
   end

   initial begin
      wait (sending_done);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
